FILE: sv/bsm_pkg.sv
`default_nettype none

package bsm_pkg;

    // Packed beat widths, fixed by the instruction and result fields.
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 56;

    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_NEWLINE = 8'h0A;

    typedef enum logic [3:0] {
        ACT_NOP     = 4'd0,
        ACT_PUSH    = 4'd1,
        ACT_ADD     = 4'd2,
        ACT_SUB     = 4'd3,
        ACT_MUL     = 4'd4,
        ACT_DIV     = 4'd5,
        ACT_PRINT   = 4'd6,
        ACT_NEWLINE = 4'd7,
        ACT_SETLOG  = 4'd8,
        ACT_PUSHR   = 4'd9,
        ACT_POPR    = 4'd10
    } act_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POP1,
        ST_POP2,
        ST_OPER,
        ST_DIV,
        ST_WRITE,
        ST_DIGIT,
        ST_DIGWR,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       start;
        logic [7:0] dividend;
        logic [7:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic       done;
        logic [7:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic [4:0] q;
        logic [3:0] r;
    } dm10_t;

    // Divide a byte by ten: q = (x * 205) >> 11 is exact for every byte value.
    function automatic dm10_t div10(input logic [7:0] x);
        logic [15:0] prod;
        logic [4:0]  q;
        logic [7:0]  tenq;
        logic [7:0]  r;
        dm10_t       res;
        prod  = 16'(x) * 16'd205;
        q     = prod[15:11];
        tenq  = {q, 3'b000} + {2'b00, q, 1'b0};
        r     = x - tenq;
        res.q = q;
        res.r = r[3:0];
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: sv/bsm_ram.sv
`default_nettype none

module bsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: sv/bsm_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module bsm_div (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire bsm_pkg::div_req_t req,
    output bsm_pkg::div_rsp_t      rsp
);

    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [7:0] rem_reg, rem_next;
    logic [7:0] quo_reg, quo_next;
    logic [7:0] dsr_reg, dsr_next;

    logic [8:0] shifted;
    logic [9:0] diff;

    always_comb begin
        shifted   = {rem_reg, quo_reg[7]};
        diff      = {1'b0, shifted} - {2'b00, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 3'd0;
            rem_next  = 8'd0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end else if (busy_reg) begin
            if (diff[9]) begin
                rem_next = shifted[7:0];
                quo_next = {quo_reg[6:0], 1'b0};
            end else begin
                rem_next = diff[7:0];
                quo_next = {quo_reg[6:0], 1'b1};
            end
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

FILE: sv/byte_stack_machine_execute_unit.sv
`default_nettype none
// One instruction is in work at a time; the next beat can be taken in the cycle after the last
// result enters the output register. The single memory read port and the 8-step divider set
// how long each instruction takes. Reset is synchronous and active low; a clearing pass that
// zeroes all MEM_BYTES stack entries follows it.

module byte_stack_machine_execute_unit #(
    parameter int MEM_BYTES = 256
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Instruction channel. s_tdata fields from bit 0: action[3:0], value[11:4], zero fill.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [bsm_pkg::S_TDATA_W-1:0]   s_tdata,
    // Result channel. m_tdata fields from bit 0: out_char[7:0], accumulator[15:8],
    // return_address[23:16], status[24], log_level[32:25], step_count[48:33], zero fill.
    // m_tuser holds kind (1 when out_char carries a character); m_tlast marks the
    // final result beat of an instruction.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [bsm_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                                 m_tlast,
    output logic                                 m_tuser
);

    localparam int AW = $clog2(MEM_BYTES);
    // Entry addressed by pointer value 255; a pointer that wraps down lands here.
    localparam int WRAP_ADDR = 255 % MEM_BYTES;

    // Each stack pointer is kept twice: its 8-bit value and its entry address
    // (value modulo MEM_BYTES), so the address follows the pointer by +1/-1 steps.
    function automatic logic [AW-1:0] addr_up(input logic [7:0] ptr, input logic [AW-1:0] addr);
        logic [AW-1:0] res;
        if (ptr == 8'hFF || addr == AW'(MEM_BYTES - 1)) begin
            res = '0;
        end else begin
            res = addr + AW'(1);
        end
        return res;
    endfunction

    function automatic logic [AW-1:0] addr_dn(input logic [7:0] ptr, input logic [AW-1:0] addr);
        logic [AW-1:0] res;
        if (ptr == 8'h00) begin
            res = AW'(WRAP_ADDR);
        end else if (addr == '0) begin
            res = AW'(MEM_BYTES - 1);
        end else begin
            res = addr - AW'(1);
        end
        return res;
    endfunction

    bsm_pkg::state_t state_reg, state_next;

    // Architectural state.
    logic [7:0]    s_ptr_reg, s_ptr_next;
    logic [AW-1:0] s_addr_reg, s_addr_next;
    logic [7:0]    r_ptr_reg, r_ptr_next;
    logic [AW-1:0] r_addr_reg, r_addr_next;
    logic [7:0]    a_reg, a_next;
    logic [7:0]    b_reg, b_next;
    logic [15:0]   cnt_reg, cnt_next;
    logic [7:0]    log_reg, log_next;

    // Per-instruction working registers.
    bsm_pkg::act_t op_reg, op_next;
    logic [7:0]    val_reg, val_next;
    logic [7:0]    ret_reg, ret_next;
    logic          status_reg, status_next;
    logic [4:0]    q1_reg, q1_next;
    logic [3:0]    r2_reg, r2_next;
    logic [7:0]    ch0_reg, ch0_next;
    logic [7:0]    ch1_reg, ch1_next;
    logic [7:0]    ch2_reg, ch2_next;
    logic [1:0]    nchar_reg, nchar_next;
    logic [1:0]    beat_reg, beat_next;
    logic [AW-1:0] clr_reg, clr_next;

    // Output register.
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [bsm_pkg::M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                            m_tlast_reg, m_tlast_next;
    logic                            m_tuser_reg, m_tuser_next;

    // Stack memory port.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    bsm_pkg::div_req_t div_req;
    bsm_pkg::div_rsp_t div_rsp;

    logic           s_accept;
    logic           slot_free;
    logic [15:0]    prod;
    bsm_pkg::dm10_t dm1;
    bsm_pkg::dm10_t dm2;
    logic [1:0]     beat_count;
    logic [7:0]     ch_sel;
    logic           beat_last;

    bsm_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bsm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_tready  = (state_reg == bsm_pkg::ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign slot_free = !m_tvalid_reg || m_tready;

    assign prod = 16'(ram_rdata) * 16'(b_reg);
    assign dm1  = bsm_pkg::div10(ram_rdata);
    assign dm2  = bsm_pkg::div10({3'b000, q1_reg});

    // A beat with no character is the only beat of its instruction.
    assign beat_count = (nchar_reg == 2'd0) ? 2'd1 : nchar_reg;
    assign beat_last  = (beat_reg == beat_count - 2'd1);

    always_comb begin
        case (beat_reg)
            2'd0:    ch_sel = ch0_reg;
            2'd1:    ch_sel = ch1_reg;
            default: ch_sel = ch2_reg;
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bsm_pkg::ST_CLEAR: begin
                if (clr_reg == AW'(MEM_BYTES - 1)) begin
                    state_next = bsm_pkg::ST_IDLE;
                end
            end
            bsm_pkg::ST_IDLE: begin
                if (s_accept) begin
                    case (bsm_pkg::act_t'(s_tdata[3:0]))
                        bsm_pkg::ACT_PUSH, bsm_pkg::ACT_PUSHR: state_next = bsm_pkg::ST_WRITE;
                        bsm_pkg::ACT_ADD, bsm_pkg::ACT_SUB, bsm_pkg::ACT_MUL,
                        bsm_pkg::ACT_DIV, bsm_pkg::ACT_PRINT, bsm_pkg::ACT_SETLOG,
                        bsm_pkg::ACT_POPR: state_next = bsm_pkg::ST_POP1;
                        default: state_next = bsm_pkg::ST_EMIT;
                    endcase
                end
            end
            bsm_pkg::ST_POP1: begin
                if (op_reg inside {bsm_pkg::ACT_ADD, bsm_pkg::ACT_SUB,
                                   bsm_pkg::ACT_MUL, bsm_pkg::ACT_DIV}) begin
                    state_next = bsm_pkg::ST_POP2;
                end else begin
                    state_next = bsm_pkg::ST_OPER;
                end
            end
            bsm_pkg::ST_POP2: state_next = bsm_pkg::ST_OPER;
            bsm_pkg::ST_OPER: begin
                case (op_reg)
                    bsm_pkg::ACT_ADD, bsm_pkg::ACT_SUB, bsm_pkg::ACT_MUL: begin
                        state_next = bsm_pkg::ST_WRITE;
                    end
                    bsm_pkg::ACT_DIV: begin
                        state_next = (b_reg == 8'd0) ? bsm_pkg::ST_WRITE : bsm_pkg::ST_DIV;
                    end
                    bsm_pkg::ACT_PRINT: state_next = bsm_pkg::ST_DIGIT;
                    default:            state_next = bsm_pkg::ST_EMIT;
                endcase
            end
            bsm_pkg::ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = bsm_pkg::ST_WRITE;
                end
            end
            bsm_pkg::ST_WRITE: state_next = bsm_pkg::ST_EMIT;
            bsm_pkg::ST_DIGIT: begin
                state_next = (q1_reg == 5'd0) ? bsm_pkg::ST_EMIT : bsm_pkg::ST_DIGWR;
            end
            bsm_pkg::ST_DIGWR: state_next = bsm_pkg::ST_EMIT;
            bsm_pkg::ST_EMIT: begin
                if (slot_free && beat_last) begin
                    state_next = bsm_pkg::ST_IDLE;
                end
            end
            default: state_next = bsm_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        s_ptr_next   = s_ptr_reg;
        s_addr_next  = s_addr_reg;
        r_ptr_next   = r_ptr_reg;
        r_addr_next  = r_addr_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        cnt_next     = cnt_reg;
        log_next     = log_reg;
        op_next      = op_reg;
        val_next     = val_reg;
        ret_next     = ret_reg;
        status_next  = status_reg;
        q1_next      = q1_reg;
        r2_next      = r2_reg;
        ch0_next     = ch0_reg;
        ch1_next     = ch1_reg;
        ch2_next     = ch2_reg;
        nchar_next   = nchar_reg;
        beat_next    = beat_reg;
        clr_next     = clr_reg;
        ram_we       = 1'b0;
        ram_waddr    = s_addr_reg;
        ram_wdata    = a_reg;
        ram_raddr    = s_addr_reg;
        div_req      = '0;
        m_tdata_next = m_tdata_reg;
        m_tlast_next = m_tlast_reg;
        m_tuser_next = m_tuser_reg;
        m_tvalid_next = (m_tvalid_reg && m_tready) ? 1'b0 : m_tvalid_reg;

        case (state_reg)
            bsm_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = 8'd0;
                clr_next  = clr_reg + AW'(1);
            end
            bsm_pkg::ST_IDLE: begin
                if (s_accept) begin
                    op_next     = bsm_pkg::act_t'(s_tdata[3:0]);
                    val_next    = s_tdata[11:4];
                    cnt_next    = cnt_reg + 16'd1;
                    ret_next    = 8'd0;
                    status_next = 1'b0;
                    beat_next   = 2'd0;
                    nchar_next  = 2'd0;
                    if (bsm_pkg::act_t'(s_tdata[3:0]) == bsm_pkg::ACT_NEWLINE) begin
                        nchar_next = 2'd1;
                        ch0_next   = bsm_pkg::ASCII_NEWLINE;
                    end
                end
            end
            bsm_pkg::ST_POP1: begin
                if (op_reg == bsm_pkg::ACT_POPR) begin
                    ram_raddr   = addr_up(r_ptr_reg, r_addr_reg);
                    r_addr_next = addr_up(r_ptr_reg, r_addr_reg);
                    r_ptr_next  = r_ptr_reg + 8'd1;
                end else begin
                    ram_raddr   = addr_dn(s_ptr_reg, s_addr_reg);
                    s_addr_next = addr_dn(s_ptr_reg, s_addr_reg);
                    s_ptr_next  = s_ptr_reg - 8'd1;
                end
            end
            bsm_pkg::ST_POP2: begin
                // Top of stack arrives; the second operand is read below it.
                b_next      = ram_rdata;
                ram_raddr   = addr_dn(s_ptr_reg, s_addr_reg);
                s_addr_next = addr_dn(s_ptr_reg, s_addr_reg);
                s_ptr_next  = s_ptr_reg - 8'd1;
            end
            bsm_pkg::ST_OPER: begin
                case (op_reg)
                    bsm_pkg::ACT_ADD: a_next = ram_rdata + b_reg;
                    bsm_pkg::ACT_SUB: a_next = ram_rdata - b_reg;
                    bsm_pkg::ACT_MUL: a_next = prod[7:0];
                    bsm_pkg::ACT_DIV: begin
                        if (b_reg == 8'd0) begin
                            // Divide by zero yields zero and flags the step.
                            a_next      = 8'd0;
                            status_next = 1'b1;
                        end else begin
                            div_req.start    = 1'b1;
                            div_req.dividend = ram_rdata;
                            div_req.divisor  = b_reg;
                        end
                    end
                    bsm_pkg::ACT_SETLOG: begin
                        a_next   = ram_rdata;
                        log_next = ram_rdata;
                    end
                    bsm_pkg::ACT_POPR: begin
                        a_next   = ram_rdata;
                        ret_next = ram_rdata;
                    end
                    bsm_pkg::ACT_PRINT: begin
                        a_next  = {4'd0, dm1.r};
                        b_next  = {3'd0, dm1.q};
                        q1_next = dm1.q;
                    end
                    default: begin
                    end
                endcase
            end
            bsm_pkg::ST_DIV: begin
                if (div_rsp.done) begin
                    a_next = div_rsp.quotient;
                end
            end
            bsm_pkg::ST_WRITE: begin
                ram_we = 1'b1;
                case (op_reg)
                    bsm_pkg::ACT_PUSH: begin
                        ram_wdata   = val_reg;
                        a_next      = val_reg;
                        s_addr_next = addr_up(s_ptr_reg, s_addr_reg);
                        s_ptr_next  = s_ptr_reg + 8'd1;
                    end
                    bsm_pkg::ACT_PUSHR: begin
                        ram_waddr   = r_addr_reg;
                        ram_wdata   = val_reg;
                        a_next      = val_reg;
                        r_addr_next = addr_dn(r_ptr_reg, r_addr_reg);
                        r_ptr_next  = r_ptr_reg - 8'd1;
                    end
                    default: begin
                        s_addr_next = addr_up(s_ptr_reg, s_addr_reg);
                        s_ptr_next  = s_ptr_reg + 8'd1;
                    end
                endcase
            end
            bsm_pkg::ST_DIGIT: begin
                // The ones digit goes back into the popped slot.
                ram_we = 1'b1;
                r2_next = dm2.r;
                if (q1_reg == 5'd0) begin
                    nchar_next = 2'd1;
                    ch0_next   = bsm_pkg::ASCII_ZERO + {4'd0, a_reg[3:0]};
                end else if (dm2.q == 5'd0) begin
                    nchar_next = 2'd2;
                    ch0_next   = bsm_pkg::ASCII_ZERO + {4'd0, dm2.r};
                    ch1_next   = bsm_pkg::ASCII_ZERO + {4'd0, a_reg[3:0]};
                end else begin
                    nchar_next = 2'd3;
                    ch0_next   = bsm_pkg::ASCII_ZERO + {3'd0, dm2.q};
                    ch1_next   = bsm_pkg::ASCII_ZERO + {4'd0, dm2.r};
                    ch2_next   = bsm_pkg::ASCII_ZERO + {4'd0, a_reg[3:0]};
                end
            end
            bsm_pkg::ST_DIGWR: begin
                // The tens digit stays one slot above the popped one.
                ram_we    = 1'b1;
                ram_waddr = addr_up(s_ptr_reg, s_addr_reg);
                ram_wdata = {4'd0, r2_reg};
            end
            bsm_pkg::ST_EMIT: begin
                if (slot_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = (nchar_reg != 2'd0);
                    m_tlast_next  = beat_last;
                    m_tdata_next  = {7'd0, cnt_reg, log_reg, status_reg, ret_reg, a_reg,
                                     (nchar_reg != 2'd0) ? ch_sel : 8'd0};
                    beat_next     = beat_reg + 2'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bsm_pkg::ST_CLEAR;
            s_ptr_reg    <= 8'd0;
            s_addr_reg   <= '0;
            r_ptr_reg    <= 8'hFF;
            r_addr_reg   <= AW'(WRAP_ADDR);
            a_reg        <= 8'd0;
            b_reg        <= 8'd0;
            cnt_reg      <= 16'd0;
            log_reg      <= 8'd0;
            clr_reg      <= '0;
            beat_reg     <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s_ptr_reg    <= s_ptr_next;
            s_addr_reg   <= s_addr_next;
            r_ptr_reg    <= r_ptr_next;
            r_addr_reg   <= r_addr_next;
            a_reg        <= a_next;
            b_reg        <= b_next;
            cnt_reg      <= cnt_next;
            log_reg      <= log_next;
            clr_reg      <= clr_next;
            beat_reg     <= beat_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        op_reg      <= op_next;
        val_reg     <= val_next;
        ret_reg     <= ret_next;
        status_reg  <= status_next;
        q1_reg      <= q1_next;
        r2_reg      <= r2_next;
        ch0_reg     <= ch0_next;
        ch1_reg     <= ch1_next;
        ch2_reg     <= ch2_next;
        nchar_reg   <= nchar_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

FILE: sv/bsm_checker.sv
`default_nettype none

module bsm_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [bsm_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [bsm_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                          m_tlast,
    input wire logic                          m_tuser
);

    // A stalled result beat holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Reset starts the clearing pass: no beat is taken or offered right after it.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("block not quiet after reset");

    // One instruction at a time: an accepted beat closes the input side.
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second instruction accepted back to back");

    // An acknowledge without a character is always the final beat.
    a_ack_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("plain acknowledge not marked last");

    // Characters are decimal digits or newline.
    a_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[7:0] >= bsm_pkg::ASCII_ZERO
                                 && m_tdata[7:0] <= bsm_pkg::ASCII_ZERO + 8'd9)
                                || m_tdata[7:0] == bsm_pkg::ASCII_NEWLINE)
        else $error("unexpected output character");

endmodule

bind byte_stack_machine_execute_unit bsm_checker u_bsm_checker (.*);

`default_nettype wire

FILE: tb/tb_byte_stack_machine_execute_unit.sv
`default_nettype none

module tb_byte_stack_machine_execute_unit;

    // Spare action codes. The unit has to treat all of them as a nop that still counts.
    localparam logic [3:0] ACT_SPARE_FIRST = 4'd11;
    localparam logic [3:0] ACT_SPARE_LAST  = 4'd15;

    // Minimum number of random instructions after the directed opening.
    localparam int RANDOM_INSTRS = 190;

    // Predictor of the execute unit together with the queue of result beats still owed.
    // execute() is called once for every instruction beat the unit accepts.
    // compare_beat() takes one result beat and returns an empty string when it matches.
    class result_scoreboard;
        localparam int STACK_BYTES = 256;

        typedef struct {
            logic        kind;
            logic [7:0]  out_char;
            logic        last;
            logic [7:0]  acc;
            logic [7:0]  ret_addr;
            logic        div_err;
            logic [7:0]  log_lvl;
            logic [15:0] steps;
        } result_beat_t;

        result_beat_t owed[$];

        bit [7:0]  mem[STACK_BYTES];
        bit [7:0]  dsp;
        bit [7:0]  rsp;
        bit [7:0]  reg_a;
        bit [7:0]  reg_b;
        bit [15:0] steps;
        bit [7:0]  log_lvl;

        function new();
            foreach (mem[i]) mem[i] = 8'd0;
            dsp     = 8'd0;
            rsp     = 8'hFF;
            reg_a   = 8'd0;
            reg_b   = 8'd0;
            steps   = 16'd0;
            log_lvl = 8'd0;
        endfunction

        function void push_a();
            mem[int'(dsp) % STACK_BYTES] = reg_a;
            dsp = dsp + 8'd1;
        endfunction

        function void pop_a();
            dsp = dsp - 8'd1;
            reg_a = mem[int'(dsp) % STACK_BYTES];
        endfunction

        // Pop the top into B and the entry below it into A.
        function void pop_operands();
            pop_a();
            reg_b = reg_a;
            pop_a();
        endfunction

        // The remainder goes to A and the quotient to B.
        function void split_tens();
            bit [7:0] quo;
            quo   = reg_a / 8'd10;
            reg_a = reg_a % 8'd10;
            reg_b = quo;
        endfunction

        function void execute(input logic [3:0] op, input logic [7:0] value);
            bit [7:0]     chars[$];
            bit [7:0]     ret_addr;
            bit           div_err;
            result_beat_t beat;
            int           count;
            ret_addr = 8'd0;
            div_err  = 1'b0;
            case (op)
                bsm_pkg::ACT_PUSH: begin
                    reg_a = value;
                    push_a();
                end
                bsm_pkg::ACT_ADD: begin
                    pop_operands();
                    reg_a = reg_a + reg_b;
                    push_a();
                end
                bsm_pkg::ACT_SUB: begin
                    pop_operands();
                    reg_a = reg_a - reg_b;
                    push_a();
                end
                bsm_pkg::ACT_MUL: begin
                    pop_operands();
                    reg_a = reg_a * reg_b;
                    push_a();
                end
                bsm_pkg::ACT_DIV: begin
                    pop_operands();
                    if (reg_b == 8'd0) begin
                        reg_a   = 8'd0;
                        div_err = 1'b1;
                    end else begin
                        reg_a = reg_a / reg_b;
                    end
                    push_a();
                end
                bsm_pkg::ACT_PRINT: begin
                    // The digits are parked on the data stack above the popped slot and
                    // then popped back, so they stay behind in memory.
                    pop_a();
                    split_tens();
                    push_a();
                    if (reg_b != 8'd0) begin
                        reg_a = reg_b;
                        split_tens();
                        push_a();
                        if (reg_b != 8'd0) chars.push_back(reg_b + bsm_pkg::ASCII_ZERO);
                        pop_a();
                        chars.push_back(reg_a + bsm_pkg::ASCII_ZERO);
                    end
                    pop_a();
                    chars.push_back(reg_a + bsm_pkg::ASCII_ZERO);
                end
                bsm_pkg::ACT_NEWLINE: begin
                    chars.push_back(bsm_pkg::ASCII_NEWLINE);
                end
                bsm_pkg::ACT_SETLOG: begin
                    pop_a();
                    log_lvl = reg_a;
                end
                bsm_pkg::ACT_PUSHR: begin
                    reg_a = value;
                    mem[int'(rsp) % STACK_BYTES] = reg_a;
                    rsp = rsp - 8'd1;
                end
                bsm_pkg::ACT_POPR: begin
                    rsp = rsp + 8'd1;
                    reg_a = mem[int'(rsp) % STACK_BYTES];
                    ret_addr = reg_a;
                end
                default: begin
                end
            endcase
            steps = steps + 16'd1;

            count = (chars.size() > 0) ? chars.size() : 1;
            for (int k = 0; k < count; k++) begin
                beat.kind     = (chars.size() > 0);
                beat.out_char = (chars.size() > 0) ? chars[k] : 8'd0;
                beat.last     = (k == count - 1);
                beat.acc      = reg_a;
                beat.ret_addr = ret_addr;
                beat.div_err  = div_err;
                beat.log_lvl  = log_lvl;
                beat.steps    = steps;
                owed.push_back(beat);
            end
        endfunction

        function string compare_beat(input logic kind, input logic [7:0] out_char,
                                     input logic last, input logic [7:0] acc,
                                     input logic [7:0] ret_addr, input logic div_err,
                                     input logic [7:0] log_lvl, input logic [15:0] steps);
            result_beat_t want;
            string        diffs;
            if (owed.size() == 0) return "result beat arrived with nothing expected";
            want  = owed.pop_front();
            diffs = "";
            if (kind !== want.kind)
                diffs = {diffs, $sformatf(" kind %0h/%0h", kind, want.kind)};
            if (out_char !== want.out_char)
                diffs = {diffs, $sformatf(" char %0h/%0h", out_char, want.out_char)};
            if (last !== want.last)
                diffs = {diffs, $sformatf(" last %0h/%0h", last, want.last)};
            if (acc !== want.acc)
                diffs = {diffs, $sformatf(" acc %0h/%0h", acc, want.acc)};
            if (ret_addr !== want.ret_addr)
                diffs = {diffs, $sformatf(" ret %0h/%0h", ret_addr, want.ret_addr)};
            if (div_err !== want.div_err)
                diffs = {diffs, $sformatf(" status %0h/%0h", div_err, want.div_err)};
            if (log_lvl !== want.log_lvl)
                diffs = {diffs, $sformatf(" log %0h/%0h", log_lvl, want.log_lvl)};
            if (steps !== want.steps)
                diffs = {diffs, $sformatf(" steps %0h/%0h", steps, want.steps)};
            if (diffs == "") return "";
            return $sformatf("instr %0d (got/want):%s", want.steps, diffs);
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    // Clock and reset. All inputs of the unit have a known value from time zero on.
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Instruction channel. s_tdata fields from bit 0: action[3:0], value[11:4], zero fill.
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [bsm_pkg::S_TDATA_W-1:0] s_tdata  = '0;

    // Result channel. m_tdata fields from bit 0: out_char[7:0], accumulator[15:8],
    // return_address[23:16], status[24], log_level[32:25], step_count[48:33], zero fill.
    // m_tuser carries kind; m_tlast marks the final result beat of an instruction.
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [bsm_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tlast;
    logic                          m_tuser;

    byte_stack_machine_execute_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    result_scoreboard sb;
    int error_count = 0;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("MISMATCH: %s", what);
    endtask

    // ------------------------------------------------------------------
    // Receiver. Every result beat is checked at the edge that takes it. Reading
    // m_tready here gives the value that held at that edge, since the update below
    // is nonblocking. The ready line follows a pattern of its own: spells of
    // constant ready, spells of coin-flip stalls and spells where ready is high
    // only one cycle in four, each lasting a random number of cycles.
    // ------------------------------------------------------------------
    int ready_mode  = 0;
    int ready_spell = 0;
    int ready_tick  = 0;

    always @(posedge aclk) begin
        string diffs;
        if (aresetn && m_tvalid && m_tready) begin
            diffs = sb.compare_beat(m_tuser, m_tdata[7:0], m_tlast, m_tdata[15:8],
                                    m_tdata[23:16], m_tdata[24], m_tdata[32:25],
                                    m_tdata[48:33]);
            if (diffs != "") report_mismatch(diffs);
        end

        if (ready_spell == 0) begin
            ready_mode  = $urandom_range(0, 2);
            ready_spell = $urandom_range(10, 60);
        end else begin
            ready_spell--;
        end
        ready_tick++;
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= (ready_tick % 4 == 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Sender. Instructions go out in bursts of random length. Between bursts there
    // is a random gap, but about a quarter of the bursts follow with no gap at all.
    // s_tvalid is lowered only when a gap actually follows, so it never gets
    // two nonblocking assignments in one time step.
    // ------------------------------------------------------------------
    int burst_left = 0;

    task automatic send_instr(input logic [3:0] op, input logic [7:0] value);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(bsm_pkg::S_TDATA_W - 12){1'b0}}, value, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // The beat was taken at this edge; its results cannot show up before a later one.
        sb.execute(op, value);
        burst_left--;
    endtask

    // Bytes for operands, biased toward the edges: zero divisors, digit-count
    // boundaries of print and the largest byte.
    function automatic logic [7:0] pick_byte();
        logic [7:0] edges[7] = '{8'd0, 8'd1, 8'd9, 8'd10, 8'd99, 8'd100, 8'd255};
        if ($urandom_range(0, 3) == 0) return edges[$urandom_range(0, 6)];
        return 8'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    initial begin
        int sent;
        sb = new();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        // After reset the unit clears its stack memory with s_tready low; the
        // first send simply waits for the handshake.

        // Directed opening: arithmetic at the byte limits and wrapping results,
        // divide by zero, print with one, two and three digits, newline, log
        // level, both return-stack actions, a nop and every spare code.
        send_instr(bsm_pkg::ACT_PUSH, 8'd0);
        send_instr(bsm_pkg::ACT_PUSH, 8'd255);
        send_instr(bsm_pkg::ACT_ADD, 8'd0);
        send_instr(bsm_pkg::ACT_PUSH, 8'd255);
        send_instr(bsm_pkg::ACT_MUL, 8'd255);
        send_instr(bsm_pkg::ACT_PUSH, 8'd7);
        send_instr(bsm_pkg::ACT_PUSH, 8'd0);
        send_instr(bsm_pkg::ACT_DIV, 8'd0);
        send_instr(bsm_pkg::ACT_PUSH, 8'd55);
        send_instr(bsm_pkg::ACT_SUB, 8'd0);
        send_instr(bsm_pkg::ACT_PUSH, 8'd255);
        send_instr(bsm_pkg::ACT_PRINT, 8'd0);
        send_instr(bsm_pkg::ACT_PUSH, 8'd42);
        send_instr(bsm_pkg::ACT_PRINT, 8'd255);
        send_instr(bsm_pkg::ACT_PUSH, 8'd5);
        send_instr(bsm_pkg::ACT_PRINT, 8'd0);
        send_instr(bsm_pkg::ACT_NEWLINE, 8'd0);
        send_instr(bsm_pkg::ACT_PUSH, 8'd3);
        send_instr(bsm_pkg::ACT_SETLOG, 8'd0);
        send_instr(bsm_pkg::ACT_PUSHR, 8'hAA);
        send_instr(bsm_pkg::ACT_PUSHR, 8'h55);
        send_instr(bsm_pkg::ACT_POPR, 8'd0);
        send_instr(bsm_pkg::ACT_POPR, 8'd0);
        send_instr(bsm_pkg::ACT_NOP, 8'd255);
        for (int code = ACT_SPARE_FIRST; code <= ACT_SPARE_LAST; code++)
            send_instr(4'(code), pick_byte());

        // Random part. Most of it is well-formed groups: two operands and an
        // arithmetic action, a value and a print, call and return pairs, a value with
        // a set log and a newline. The rest is single instructions of any code, which
        // also lets the stacks drift, underflow and wrap.
        sent = 0;
        while (sent < RANDOM_INSTRS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    send_instr(bsm_pkg::ACT_PUSH, pick_byte());
                    send_instr(bsm_pkg::ACT_PUSH, pick_byte());
                    send_instr(4'($urandom_range(bsm_pkg::ACT_ADD, bsm_pkg::ACT_DIV)),
                               pick_byte());
                    sent += 3;
                end
                4, 5: begin
                    send_instr(bsm_pkg::ACT_PUSH, pick_byte());
                    send_instr(bsm_pkg::ACT_PRINT, pick_byte());
                    sent += 2;
                end
                6: begin
                    send_instr(bsm_pkg::ACT_PUSHR, pick_byte());
                    send_instr(bsm_pkg::ACT_PUSHR, pick_byte());
                    send_instr(bsm_pkg::ACT_POPR, pick_byte());
                    send_instr(bsm_pkg::ACT_POPR, pick_byte());
                    sent += 4;
                end
                7: begin
                    send_instr(bsm_pkg::ACT_PUSH, pick_byte());
                    send_instr(bsm_pkg::ACT_SETLOG, pick_byte());
                    send_instr(bsm_pkg::ACT_NEWLINE, pick_byte());
                    sent += 3;
                end
                default: begin
                    send_instr(4'($urandom_range(0, 15)), pick_byte());
                    sent += 1;
                end
            endcase
        end
        s_tvalid <= 1'b0;

        // Drain: wait for every owed result beat, then give the unit time to show
        // any extra beat it should not produce. The longest latency is a divide.
        while (sb.pending() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog. A correct run ends well before it fires, including the clearing
    // pass after reset and the worst stalls on both sides.
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
